FILE: design/bldc6_pkg.sv
// ----------------------------------------------------------------------------
// bldc6_pkg
// Shared types, register indexes, reset values and step tables for the
// six-step hall commutator.
// ----------------------------------------------------------------------------
`default_nettype none

package bldc6_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERTED_PWM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DUTY   = 2'd2;

    localparam logic REQ_HALL   = 1'b0;
    localparam logic REQ_BUTTON = 1'b1;

    localparam logic [15:0] RST_PERIOD   = 16'd1000;
    localparam logic [15:0] RST_STEP_INC = 16'd50;
    localparam logic [15:0] RST_LIM_HI   = 16'd300;
    localparam logic [15:0] RST_LIM_LO   = 16'd100;

    // floor(x/10) is exact for x < 2^18 with this reciprocal
    localparam logic [16:0] RECIP10  = 17'd52429;
    localparam int          RECIP_SH = 19;

    typedef struct packed {
        logic       req_type;
        logic [2:0] hall_bits;
        logic       dir_button;
        logic       speed_button;
    } t_in_item;

    typedef struct packed {
        logic [15:0] cmp_one;
        logic [15:0] cmp_two;
        logic [15:0] cmp_three;
        logic [2:0]  high_enable;
        logic [2:0]  low_enable;
        logic [2:0]  low_pins;
        logic        high_pins_cleared;
        logic        commutated;
        logic [15:0] duty_now;
        logic        reverse_now;
    } t_out_item;

    typedef struct packed {
        logic [15:0] period;
        logic        inverted;
        logic [15:0] step_inc;
        logic [15:0] lim_hi;
        logic [15:0] lim_lo;
    } t_cfg;

    function automatic logic [15:0] div10(input logic [17:0] x);
        logic [34:0] p;
        p = 35'(x) * 35'(RECIP10);
        return p[RECIP_SH+15:RECIP_SH];
    endfunction

    // channel that carries a zero compare for steps 1..6
    function automatic logic [1:0] step_zero_chan(input logic [2:0] s);
        logic [1:0] r;
        unique case (s)
            3'd1:    r = 2'd1;
            3'd2:    r = 2'd2;
            3'd3:    r = 2'd0;
            3'd4:    r = 2'd0;
            3'd5:    r = 2'd2;
            3'd6:    r = 2'd1;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] step_hi_en(input logic [2:0] s);
        logic [2:0] r;
        unique case (s)
            3'd1:    r = 3'd1;
            3'd2:    r = 3'd2;
            3'd3:    r = 3'd2;
            3'd4:    r = 3'd4;
            3'd5:    r = 3'd1;
            3'd6:    r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // low-side enables and low pins share one pattern
    function automatic logic [2:0] step_lo_en(input logic [2:0] s);
        logic [2:0] r;
        unique case (s)
            3'd1:    r = 3'd4;
            3'd2:    r = 3'd1;
            3'd3:    r = 3'd4;
            3'd4:    r = 3'd2;
            3'd5:    r = 3'd2;
            3'd6:    r = 3'd1;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/bldc6_cfg.sv
// ----------------------------------------------------------------------------
// bldc6_cfg
// Configuration registers; duty ramp step and limits derived on period write.
// ----------------------------------------------------------------------------
`default_nettype none

module bldc6_cfg
    import bldc6_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr,
    input  wire logic [CFG_IDX_W-1:0] i_idx,
    input  wire logic [15:0]          i_data,
    output t_cfg                      o_cfg,
    output logic                      o_duty_load
);

    t_cfg        r_cfg;
    logic [15:0] lo_val;
    logic [17:0] x3;

    assign lo_val = div10({2'b00, i_data});
    assign x3     = {1'b0, i_data, 1'b0} + {2'b00, i_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period   <= RST_PERIOD;
            r_cfg.inverted <= 1'b0;
            r_cfg.step_inc <= RST_STEP_INC;
            r_cfg.lim_hi   <= RST_LIM_HI;
            r_cfg.lim_lo   <= RST_LIM_LO;
        end else if (i_wr) begin
            unique case (i_idx)
                CFG_PWM_PERIOD: begin
                    r_cfg.period   <= i_data;
                    r_cfg.lim_lo   <= lo_val;
                    r_cfg.step_inc <= {1'b0, lo_val[15:1]};
                    r_cfg.lim_hi   <= div10(x3);
                end
                CFG_INVERTED_PWM: begin
                    r_cfg.inverted <= i_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg       = r_cfg;
    assign o_duty_load = i_wr && (i_idx == CFG_START_DUTY);

endmodule

`default_nettype wire

FILE: design/bldc6_core.sv
// ----------------------------------------------------------------------------
// bldc6_core
// Commutation, button state; result for one beat per cycle while i_adv is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bldc6_core
    import bldc6_pkg::*;
#(
    parameter int DUTY_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_adv,
    input  wire t_in_item    i_item,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_duty_load,
    input  wire logic [15:0] i_duty_val,
    output t_out_item        o_res
);

    localparam int CW = (DUTY_BITS > 16) ? DUTY_BITS : 16;

    logic [2:0]           r_last_hall, n_last_hall;
    logic [DUTY_BITS-1:0] r_duty, n_duty;
    logic                 r_reverse, n_reverse;
    logic                 r_ramp_up, n_ramp_up;
    logic                 r_dir_armed, n_dir_armed;
    logic                 r_spd_armed, n_spd_armed;
    logic [15:0]          r_cmp [3];
    logic [15:0]          n_cmp [3];
    logic [2:0]           r_hi_en, n_hi_en;
    logic [2:0]           r_lo_en, n_lo_en;
    logic [2:0]           r_lo_pins, n_lo_pins;
    logic                 r_cleared, n_cleared;

    logic                 is_hall;
    logic                 hall_change;
    logic [2:0]           hall;
    logic [2:0]           step;
    logic                 step_ok;
    logic [15:0]          duty16;
    logic [15:0]          drv;
    logic [1:0]           zc;
    logic [DUTY_BITS-1:0] sum_up;
    logic [DUTY_BITS-1:0] diff_dn;
    logic                 commutated;

    assign hall        = i_item.hall_bits;
    assign is_hall     = (i_item.req_type == REQ_HALL);
    assign hall_change = is_hall && (hall != r_last_hall);
    assign step        = !r_reverse ? hall :
                         ((hall != 3'd0 && hall != 3'd7) ? 3'd7 - hall : 3'd0);
    assign step_ok     = (step != 3'd0) && (step != 3'd7);
    assign duty16      = 16'(r_duty);
    assign drv         = i_cfg.inverted ? i_cfg.period - duty16 : duty16;
    assign zc          = step_zero_chan(step);
    assign sum_up      = r_duty + DUTY_BITS'(i_cfg.step_inc);
    assign diff_dn     = r_duty - DUTY_BITS'(i_cfg.step_inc);

    always_comb begin
        n_last_hall = r_last_hall;
        n_duty      = r_duty;
        n_reverse   = r_reverse;
        n_ramp_up   = r_ramp_up;
        n_dir_armed = r_dir_armed;
        n_spd_armed = r_spd_armed;
        n_cmp       = r_cmp;
        n_hi_en     = r_hi_en;
        n_lo_en     = r_lo_en;
        n_lo_pins   = r_lo_pins;
        n_cleared   = r_cleared;
        commutated  = 1'b0;

        if (i_adv && hall_change) begin
            commutated  = 1'b1;
            n_last_hall = hall;
            if (step_ok) begin
                for (int c = 0; c < 3; c++) begin
                    n_cmp[c] = (2'(c) == zc) ? 16'd0 : drv;
                end
                n_hi_en   = step_hi_en(step);
                n_lo_en   = step_lo_en(step);
                n_lo_pins = step_lo_en(step);
                n_cleared = 1'b0;
            end else begin
                n_hi_en   = 3'd0;
                n_lo_en   = 3'd0;
                n_cleared = 1'b1;
            end
        end

        if (i_adv && !is_hall) begin
            if (i_item.dir_button) begin
                n_dir_armed = 1'b1;
            end else if (r_dir_armed) begin
                n_dir_armed = 1'b0;
                n_reverse   = !r_reverse;
            end
            if (i_item.speed_button) begin
                n_spd_armed = 1'b1;
            end else if (r_spd_armed) begin
                n_spd_armed = 1'b0;
                if (r_ramp_up) begin
                    if (CW'(sum_up) > CW'(i_cfg.lim_hi)) begin
                        n_duty    = DUTY_BITS'(i_cfg.lim_hi);
                        n_ramp_up = 1'b0;
                    end else begin
                        n_duty = sum_up;
                    end
                end else begin
                    if (CW'(r_duty) > CW'(i_cfg.lim_lo)) begin
                        n_duty = diff_dn;
                    end else begin
                        n_duty    = DUTY_BITS'(i_cfg.lim_lo);
                        n_ramp_up = 1'b1;
                    end
                end
            end
        end

        if (i_duty_load) begin
            n_duty = DUTY_BITS'(i_duty_val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_hall <= 3'd0;
            r_duty      <= '0;
            r_reverse   <= 1'b0;
            r_ramp_up   <= 1'b1;
            r_dir_armed <= 1'b0;
            r_spd_armed <= 1'b0;
            r_cmp[0]    <= 16'd0;
            r_cmp[1]    <= 16'd0;
            r_cmp[2]    <= 16'd0;
            r_hi_en     <= 3'd0;
            r_lo_en     <= 3'd0;
            r_lo_pins   <= 3'd0;
            r_cleared   <= 1'b0;
        end else begin
            r_last_hall <= n_last_hall;
            r_duty      <= n_duty;
            r_reverse   <= n_reverse;
            r_ramp_up   <= n_ramp_up;
            r_dir_armed <= n_dir_armed;
            r_spd_armed <= n_spd_armed;
            r_cmp       <= n_cmp;
            r_hi_en     <= n_hi_en;
            r_lo_en     <= n_lo_en;
            r_lo_pins   <= n_lo_pins;
            r_cleared   <= n_cleared;
        end
    end

    always_comb begin
        o_res.cmp_one           = n_cmp[0];
        o_res.cmp_two           = n_cmp[1];
        o_res.cmp_three         = n_cmp[2];
        o_res.high_enable       = n_hi_en;
        o_res.low_enable        = n_lo_en;
        o_res.low_pins          = n_lo_pins;
        o_res.high_pins_cleared = n_cleared;
        o_res.commutated        = commutated;
        o_res.duty_now          = 16'(n_duty);
        o_res.reverse_now       = n_reverse;
    end

endmodule

`default_nettype wire

FILE: design/bldc_six_step_commutator_top.sv
// ----------------------------------------------------------------------------
// bldc_six_step_commutator_top
// Hall six-step commutator with direction and speed ramp buttons.
//
//   channel   signals                                  beat
//   in        i_in_valid / o_in_ready / i_in_data      one hall or button sample
//   out       o_out_valid / i_out_ready / o_out_data   one result per sample
//   cfg       i_cfg_valid / o_cfg_ready / i_cfg_index, i_cfg_data
//
// One beat per cycle sustained while i_out_ready does not stall the result.
// Input register, state update, result register; the result register
// stalls on i_out_ready and the input register then holds one more beat.
// Synchronous active-low reset; cfg always ready, ramp limits computed on write.
// ----------------------------------------------------------------------------
`default_nettype none

module bldc_six_step_commutator_top
    import bldc6_pkg::*;
#(
    parameter int DUTY_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_item             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_item                 o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]          i_cfg_data
);

    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;
    logic      adv;
    t_cfg      cfg;
    logic      duty_load;
    t_out_item res;

    assign adv         = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (adv) begin
            r_out <= res;
        end
    end

    bldc6_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (i_cfg_valid),
        .i_idx       (i_cfg_index),
        .i_data      (i_cfg_data),
        .o_cfg       (cfg),
        .o_duty_load (duty_load)
    );

    bldc6_core #(
        .DUTY_BITS (DUTY_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_item      (r_in),
        .i_cfg       (cfg),
        .i_duty_load (duty_load),
        .i_duty_val  (i_cfg_data),
        .o_res       (res)
    );

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

FILE: tb/commutation_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// commutation_checker
// Watches the sample, result and register channels of the six-step
// commutator, runs its own copy of the commutator state and checks every
// result beat, field by field, against the prediction for the oldest
// outstanding sample.
// ----------------------------------------------------------------------------
module commutation_checker
    import bldc6_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_in_item             i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_out_item            i_out_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    output int unsigned          o_fail_count,
    output int unsigned          o_pending,
    output int unsigned          o_n_checked,
    output int unsigned          o_n_commutations,
    output int unsigned          o_n_ramps,
    output int unsigned          o_n_reversals
);

    localparam int REPORT_LIMIT = 10;

    // three bits per step, step 0 in the low bits
    localparam logic [20:0] HI_EN_BY_STEP = {3'd4, 3'd1, 3'd4, 3'd2, 3'd2, 3'd1, 3'd0};
    localparam logic [20:0] LO_EN_BY_STEP = {3'd1, 3'd2, 3'd2, 3'd4, 3'd1, 3'd4, 3'd0};
    // channel held at zero compare, two bits per step
    localparam logic [13:0] ZERO_CH_BY_STEP = {2'd1, 2'd2, 2'd0, 2'd0, 2'd2, 2'd1, 2'd0};

    logic [15:0] period;
    logic        inverted;
    logic [15:0] duty;
    logic [2:0]  last_hall;
    logic        reverse;
    logic        ramp_up;
    logic        dir_armed;
    logic        speed_armed;
    logic [15:0] cmp_regs [3];
    logic [2:0]  hi_en;
    logic [2:0]  lo_en;
    logic [2:0]  lo_pins;
    logic        pins_cleared;

    t_out_item   want_results [$];

    task automatic clear_model();
        period       = RST_PERIOD;
        inverted     = 1'b0;
        duty         = 16'd0;
        last_hall    = 3'd0;
        reverse      = 1'b0;
        ramp_up      = 1'b1;
        dir_armed    = 1'b0;
        speed_armed  = 1'b0;
        cmp_regs[0]  = 16'd0;
        cmp_regs[1]  = 16'd0;
        cmp_regs[2]  = 16'd0;
        hi_en        = 3'd0;
        lo_en        = 3'd0;
        lo_pins      = 3'd0;
        pins_cleared = 1'b0;
    endtask

    task automatic ramp_duty();
        int unsigned inc;
        int unsigned hi_lim;
        int unsigned lo_lim;
        inc    = period / 20;
        hi_lim = (period * 3) / 10;
        lo_lim = period / 10;
        o_n_ramps++;
        if (ramp_up) begin
            duty = duty + inc[15:0];
            if (duty > hi_lim) begin
                duty    = hi_lim[15:0];
                ramp_up = 1'b0;
            end
        end else if (duty > lo_lim) begin
            duty = duty - inc[15:0];
        end else begin
            duty    = lo_lim[15:0];
            ramp_up = 1'b1;
        end
    endtask

    task automatic apply_step(input logic [2:0] step);
        logic [15:0] drive;
        int          c;
        if (step >= 3'd1 && step <= 3'd6) begin
            drive = inverted ? period - duty : duty;
            for (c = 0; c < 3; c++) begin
                cmp_regs[c] = (c == ZERO_CH_BY_STEP[2*step +: 2]) ? 16'd0 : drive;
            end
            hi_en        = HI_EN_BY_STEP[3*step +: 3];
            lo_en        = LO_EN_BY_STEP[3*step +: 3];
            lo_pins      = LO_EN_BY_STEP[3*step +: 3];
            pins_cleared = 1'b0;
        end else begin
            // invalid step: everything off, compares and low pins kept
            hi_en        = 3'd0;
            lo_en        = 3'd0;
            pins_cleared = 1'b1;
        end
    endtask

    task automatic advance_commutator(input t_in_item s, output t_out_item r);
        logic [2:0] step;
        logic       moved;
        moved = 1'b0;
        if (s.req_type == REQ_HALL) begin
            if (s.hall_bits != last_hall) begin
                last_hall = s.hall_bits;
                step = s.hall_bits;
                if (reverse) begin
                    step = (step >= 3'd1 && step <= 3'd6) ? 3'd7 - step : 3'd0;
                end
                apply_step(step);
                moved = 1'b1;
                o_n_commutations++;
            end
        end else begin
            if (s.dir_button) begin
                dir_armed = 1'b1;
            end else if (dir_armed) begin
                dir_armed = 1'b0;
                reverse   = ~reverse;
                o_n_reversals++;
            end
            if (s.speed_button) begin
                speed_armed = 1'b1;
            end else if (speed_armed) begin
                speed_armed = 1'b0;
                ramp_duty();
            end
        end
        r.cmp_one           = cmp_regs[0];
        r.cmp_two           = cmp_regs[1];
        r.cmp_three         = cmp_regs[2];
        r.high_enable       = hi_en;
        r.low_enable        = lo_en;
        r.low_pins          = lo_pins;
        r.high_pins_cleared = pins_cleared;
        r.commutated        = moved;
        r.duty_now          = duty;
        r.reverse_now       = reverse;
    endtask

    task automatic flag_failure(input string msg);
        o_fail_count++;
        if (o_fail_count <= REPORT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string nm, input logic [15:0] want, input logic [15:0] got,
                               inout bit bad, inout string diffs);
        if (got !== want) begin
            bad   = 1'b1;
            diffs = {diffs, $sformatf(" %s exp %0d got %0d", nm, want, got)};
        end
    endtask

    // all channels are driven at the rising edge, so the values seen here
    // are the ones the block takes at the next rising edge
    always @(negedge i_clk) begin : watch
        t_out_item want;
        bit        bad;
        string     diffs;
        if (!i_rst_n) begin
            clear_model();
            want_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_n_checked++;
                if (want_results.size() == 0) begin
                    flag_failure($sformatf("result beat %h with nothing outstanding", i_out_data));
                end else begin
                    want  = want_results.pop_front();
                    bad   = 1'b0;
                    diffs = "";
                    check_field("cmp_one", want.cmp_one, i_out_data.cmp_one, bad, diffs);
                    check_field("cmp_two", want.cmp_two, i_out_data.cmp_two, bad, diffs);
                    check_field("cmp_three", want.cmp_three, i_out_data.cmp_three, bad, diffs);
                    check_field("high_enable", 16'(want.high_enable),
                                16'(i_out_data.high_enable), bad, diffs);
                    check_field("low_enable", 16'(want.low_enable),
                                16'(i_out_data.low_enable), bad, diffs);
                    check_field("low_pins", 16'(want.low_pins), 16'(i_out_data.low_pins),
                                bad, diffs);
                    check_field("high_pins_cleared", 16'(want.high_pins_cleared),
                                16'(i_out_data.high_pins_cleared), bad, diffs);
                    check_field("commutated", 16'(want.commutated),
                                16'(i_out_data.commutated), bad, diffs);
                    check_field("duty_now", want.duty_now, i_out_data.duty_now, bad, diffs);
                    check_field("reverse_now", 16'(want.reverse_now),
                                16'(i_out_data.reverse_now), bad, diffs);
                    if (bad) begin
                        flag_failure($sformatf("result beat %0d:%s", o_n_checked, diffs));
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PWM_PERIOD:   period   = i_cfg_data;
                    CFG_INVERTED_PWM: inverted = i_cfg_data[0];
                    CFG_START_DUTY:   duty     = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                advance_commutator(i_in_data, want);
                want_results.push_back(want);
            end
        end
        o_pending = want_results.size();
    end

endmodule

FILE: tb/tb_bldc_six_step_commutator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bldc_six_step_commutator_top
// Drives hall and button samples and register writes into the commutator
// with random gaps and receiver stalls, including long output hold-offs.
// A directed opening covers every step, both directions, invalid codes and
// the upper duty ramp limit; random phases follow under several register
// settings. The checker instance predicts and compares all results.
// ----------------------------------------------------------------------------
module tb_bldc_six_step_commutator_top;
    import bldc6_pkg::*;

    localparam int          HALF_PERIOD    = 6;
    localparam int          RESET_CYCLES   = 5;
    localparam int          PHASE_ITEMS    = 147;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int unsigned LONG_HOLD      = 400;
    localparam int unsigned FIRST_HOLD_AT  = 200;
    localparam int unsigned SECOND_HOLD_AT = 700;

    // forward rotation order of hall codes, first code in the low bits
    localparam logic [17:0] HALL_ORDER = {3'd5, 3'd4, 3'd6, 3'd2, 3'd3, 3'd1};

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 smp_valid = 1'b0;
    logic                 smp_ready;
    t_in_item             smp_data  = '0;
    logic                 res_valid;
    logic                 res_ready = 1'b0;
    t_out_item            res_data;
    logic                 reg_valid = 1'b0;
    logic                 reg_ready;
    logic [CFG_IDX_W-1:0] reg_index = '0;
    logic [15:0]          reg_data  = '0;

    int unsigned fails;
    int unsigned pending;
    int unsigned n_checked;
    int unsigned n_commutations;
    int unsigned n_ramps;
    int unsigned n_reversals;
    int unsigned settings = 0;
    int unsigned quiet    = 0;

    bldc_six_step_commutator_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (smp_valid),
        .o_in_ready  (smp_ready),
        .i_in_data   (smp_data),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .o_out_data  (res_data),
        .i_cfg_valid (reg_valid),
        .o_cfg_ready (reg_ready),
        .i_cfg_index (reg_index),
        .i_cfg_data  (reg_data)
    );

    commutation_checker checker_i (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (smp_valid),
        .i_in_ready       (smp_ready),
        .i_in_data        (smp_data),
        .i_out_valid      (res_valid),
        .i_out_ready      (res_ready),
        .i_out_data       (res_data),
        .i_cfg_valid      (reg_valid),
        .i_cfg_ready      (reg_ready),
        .i_cfg_index      (reg_index),
        .i_cfg_data       (reg_data),
        .o_fail_count     (fails),
        .o_pending        (pending),
        .o_n_checked      (n_checked),
        .o_n_commutations (n_commutations),
        .o_n_ramps        (n_ramps),
        .o_n_reversals    (n_reversals)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // mostly short, a few long
    function automatic int unsigned idle_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_item hall_sample(input logic [2:0] h);
        t_in_item s;
        s.req_type     = REQ_HALL;
        s.hall_bits    = h;
        s.dir_button   = 1'($urandom_range(0, 1));
        s.speed_button = 1'($urandom_range(0, 1));
        return s;
    endfunction

    function automatic t_in_item button_sample(input logic d, input logic v);
        t_in_item s;
        s.req_type     = REQ_BUTTON;
        s.hall_bits    = 3'($urandom_range(0, 7));
        s.dir_button   = d;
        s.speed_button = v;
        return s;
    endfunction

    task automatic send_sample(input t_in_item s, input bit with_gaps);
        int unsigned gap;
        bit          taken;
        smp_valid <= 1'b1;
        smp_data  <= s;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = smp_valid && smp_ready;
            @(posedge clk);
        end
        gap = with_gaps ? idle_len() : 0;
        if (gap != 0) begin
            smp_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        bit taken;
        reg_valid <= 1'b1;
        reg_index <= idx;
        reg_data  <= val;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = reg_valid && reg_ready;
            @(posedge clk);
        end
    endtask

    task automatic program_regs(input logic [15:0] period, input logic inverted,
                                input logic [15:0] start);
        smp_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        write_reg(CFG_PWM_PERIOD, period);
        write_reg(CFG_INVERTED_PWM, {15'd0, inverted});
        write_reg(CFG_START_DUTY, start);
        reg_valid <= 1'b0;
        settings++;
    endtask

    // mostly walks the rotation order, now and then reversing, with odd
    // codes, repeats and button samples mixed in
    task automatic run_random(input int n, input bit with_gaps);
        int unsigned pick;
        int unsigned pos;
        bit          backward;
        logic [2:0]  h;
        pos      = $urandom_range(0, 5);
        backward = 1'($urandom_range(0, 1));
        h        = HALL_ORDER[3*pos +: 3];
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                if ($urandom_range(0, 9) == 0) backward = ~backward;
                pos = backward ? (pos + 5) % 6 : (pos + 1) % 6;
                h   = HALL_ORDER[3*pos +: 3];
                send_sample(hall_sample(h), with_gaps);
            end else if (pick < 63) begin
                h = 3'($urandom_range(0, 7));
                send_sample(hall_sample(h), with_gaps);
            end else if (pick < 68) begin
                send_sample(hall_sample(h), with_gaps);
            end else begin
                send_sample(button_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))),
                            with_gaps);
            end
        end
    endtask

    // receiver: random ready with two long hold-offs to back up the input
    initial begin : receiver
        int unsigned run_left;
        int unsigned stall_left;
        int unsigned taken;
        int unsigned next_hold;
        run_left   = 0;
        stall_left = 0;
        taken      = 0;
        next_hold  = FIRST_HOLD_AT;
        forever begin
            @(negedge clk);
            if (res_valid && res_ready) taken++;
            @(posedge clk);
            if (taken >= next_hold) begin
                stall_left = LONG_HOLD;
                run_left   = 0;
                next_hold  = (next_hold == FIRST_HOLD_AT) ? SECOND_HOLD_AT : 32'hFFFF_FFFF;
            end else if (stall_left == 0 && run_left == 0) begin
                if ($urandom_range(0, 3) == 0) stall_left = idle_len();
                else run_left = $urandom_range(1, 16);
            end
            res_ready <= (stall_left == 0);
            if (stall_left != 0) stall_left--;
            else if (run_left != 0) run_left--;
        end
    end

    always @(negedge clk) begin
        if (!rst_n || (smp_valid && smp_ready) || (res_valid && res_ready) ||
            (reg_valid && reg_ready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("bldc_six_step_commutator_top regression: fail");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every step both ways, repeats, invalid codes, upper ramp limit
        program_regs(16'd1000, 1'b0, 16'd260);
        send_sample(hall_sample(3'd0), 1'b1);
        send_sample(hall_sample(3'd5), 1'b1);
        send_sample(hall_sample(3'd4), 1'b1);
        send_sample(hall_sample(3'd6), 1'b1);
        send_sample(hall_sample(3'd2), 1'b1);
        send_sample(hall_sample(3'd3), 1'b1);
        send_sample(hall_sample(3'd1), 1'b1);
        send_sample(hall_sample(3'd1), 1'b1);
        send_sample(hall_sample(3'd7), 1'b1);
        send_sample(hall_sample(3'd0), 1'b1);
        send_sample(button_sample(1'b1, 1'b0), 1'b1);
        send_sample(button_sample(1'b0, 1'b1), 1'b1);
        send_sample(hall_sample(3'd1), 1'b1);
        send_sample(hall_sample(3'd2), 1'b1);
        send_sample(hall_sample(3'd3), 1'b1);
        send_sample(hall_sample(3'd4), 1'b1);
        send_sample(hall_sample(3'd5), 1'b1);
        send_sample(hall_sample(3'd6), 1'b1);
        send_sample(button_sample(1'b1, 1'b0), 1'b1);
        send_sample(button_sample(1'b0, 1'b0), 1'b1);
        send_sample(button_sample(1'b0, 1'b1), 1'b1);
        send_sample(button_sample(1'b0, 1'b0), 1'b1);
        send_sample(hall_sample(3'd7), 1'b1);
        send_sample(hall_sample(3'd3), 1'b1);

        program_regs(16'd1000, 1'b0, 16'd100);
        run_random(PHASE_ITEMS, 1'b0);
        program_regs(16'hFFFF, 1'b1, 16'hFFFF);
        run_random(PHASE_ITEMS, 1'b1);
        program_regs(16'd0, 1'b0, 16'd0);
        run_random(PHASE_ITEMS, 1'b1);
        program_regs(16'd20, 1'b1, 16'd3);
        run_random(PHASE_ITEMS, 1'b1);
        program_regs(16'd100, 1'b1, 16'd5000);
        run_random(PHASE_ITEMS, 1'b1);
        program_regs(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                     16'($urandom_range(0, 65535)));
        run_random(PHASE_ITEMS, 1'b1);
        program_regs(16'd40000, 1'b0, 16'd12000);
        run_random(PHASE_ITEMS, 1'b1);

        smp_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d result beats under %0d register settings", n_checked, settings);
        $display("  %0d commutations, %0d duty ramp steps, %0d direction changes, %0d mismatches",
                 n_commutations, n_ramps, n_reversals, fails);
        if (fails == 0 && pending == 0) begin
            $display("bldc_six_step_commutator_top regression: pass");
        end else begin
            $display("bldc_six_step_commutator_top regression: fail");
        end
        $finish;
    end

endmodule

FILE: bldc_six_step_commutator_top.f
design/bldc6_pkg.sv
design/bldc6_cfg.sv
design/bldc6_core.sv
design/bldc_six_step_commutator_top.sv
tb/commutation_checker.sv
tb/tb_bldc_six_step_commutator_top.sv
